// ===== rtl/iirst_pkg.sv =====
// Package for the strided-tap IIR filter: payload structs, request codes,
// register indexes, controller states and sample limits. No dependencies.
package iirst_pkg;

    localparam int SMP_W     = 24;
    localparam int COEF_W    = 24;
    localparam int IDX_W     = 7;
    localparam int SPAN_W    = 7;
    localparam int STRIDE_W  = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 7;
    localparam int PROD_W    = SMP_W + COEF_W;
    localparam int FRAC_SHIFT = 20;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_WR_FF  = 2'd1;
    localparam logic [1:0] REQ_WR_FB  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 1'd1;

    localparam logic [SMP_W-1:0] SMP_MAX = 24'h7FFFFF;
    localparam logic [SMP_W-1:0] SMP_MIN = 24'h800000;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [IDX_W-1:0]        coef_index;
        logic signed [COEF_W-1:0] coef_value;
        logic signed [SMP_W-1:0]  sample_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample_out;
        logic                    saturated;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COEF_RD,
        ST_COEF_WR,
        ST_START,
        ST_FF,
        ST_FB,
        ST_SUM,
        ST_FIN
    } t_state;

endpackage

// ===== rtl/iirst_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module iirst_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 65
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/iir_filter_strided_taps.sv =====
// Strided-tap direct-form-I IIR filter: top level with controller, shared MAC
// and two memories (histories, coefficients). Uses iirst_pkg and iirst_ram.
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+----------------------------
//  input    | in        | i_in_valid / o_in_stall     | i_in_data  (t_in_item)
//  output   | out       | o_out_valid / i_out_stall   | o_out_data (t_out_item)
//  config   | in        | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// A sample runs over T = floor(n/stride) + 1 taps, n = min(span, MAX_SPAN), and the
// input stays stalled until it is done: one shared 24x24 multiplier forms a
// feedforward and a feedback product for each tap. A coefficient write reads,
// merges and writes back a memory row. After reset a clearing pass zeroes every
// row of both memories; the input stalls meanwhile. A finished result waits in
// the output register, and a sample holds in its last step until that register
// is free.
module iir_filter_strided_taps #(
    parameter int MAX_SPAN = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  iirst_pkg::t_in_item          i_in_data,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    output iirst_pkg::t_out_item         o_out_data,
    input  logic                         i_out_stall,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [iirst_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [iirst_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    import iirst_pkg::*;

    localparam int DEPTH = MAX_SPAN + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = ((AW > STRIDE_W) ? AW : STRIDE_W) + 1;
    localparam int XW    = (AW > IDX_W) ? AW : IDX_W;
    localparam int ACC_W = PROD_W + $clog2(2 * MAX_SPAN + 1) + 1;
    localparam int Q_W   = ACC_W - FRAC_SHIFT;
    localparam int MW    = SMP_W + COEF_W;

    t_state r_state, n_state;

    logic [SPAN_W-1:0]   r_span;
    logic [STRIDE_W-1:0] r_stride;
    t_in_item            r_req;
    logic [AW-1:0]       r_ptr;
    logic [AW-1:0]       r_clr;
    logic [AW-1:0]       r_k;
    logic [AW-1:0]       r_haddr;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                r_out_vld;
    t_out_item           r_out;

    // Memory ports.
    logic          hist_we, hist_re, coef_we, coef_re;
    logic [AW-1:0] hist_waddr, hist_raddr, coef_waddr, coef_raddr;
    logic [MW-1:0] hist_wdata, coef_wdata, hist_rdata, coef_rdata;

    logic                in_xfer, out_free, idx_ok, more_taps;
    logic [STRIDE_W-1:0] stride;
    logic [AW-1:0]       n_clamp, haddr0, k_next, haddr_next;
    logic [SW-1:0]       haddr0_sum, haddr_next_sum;
    logic signed [COEF_W-1:0] mul_c;
    logic signed [SMP_W-1:0]  mul_d;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic [Q_W-1:0]      q;
    logic                q_sat;
    logic [SMP_W-1:0]    q_out;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_vld || !i_out_stall;
    assign idx_ok   = XW'(i_in_data.coef_index) <= XW'(MAX_SPAN);
    assign stride   = (r_stride == '0) ? STRIDE_W'(1) : r_stride;
    assign n_clamp  = (XW'(r_span) > XW'(MAX_SPAN)) ? AW'(MAX_SPAN) : AW'(r_span);

    // History slot of the first tap: (ptr - n) mod DEPTH.
    assign haddr0_sum = SW'(r_ptr) + SW'(DEPTH) - SW'(n_clamp);
    assign haddr0     = (haddr0_sum >= SW'(DEPTH)) ? AW'(haddr0_sum - SW'(DEPTH))
                                                   : AW'(haddr0_sum);

    // Stepping k down by the stride moves the history slot up by the stride.
    assign more_taps      = SW'(r_k) >= SW'(stride);
    assign k_next         = AW'(SW'(r_k) - SW'(stride));
    assign haddr_next_sum = SW'(r_haddr) + SW'(stride);
    assign haddr_next     = (haddr_next_sum >= SW'(DEPTH))
                            ? AW'(haddr_next_sum - SW'(DEPTH)) : AW'(haddr_next_sum);

    // Shared multiplier: b*x in ST_FF, a*y in ST_FB. Tap zero uses the new sample.
    always_comb begin
        mul_c = coef_rdata[COEF_W-1:0];
        mul_d = hist_rdata[SMP_W-1:0];
        if (r_state == ST_FF) begin
            mul_c = coef_rdata[MW-1:SMP_W];
            mul_d = (r_k == '0) ? r_req.sample_in : hist_rdata[MW-1:SMP_W];
        end
    end
    assign mul_p = mul_c * mul_d;

    // Round half up, shift to Q1.23 and clamp.
    assign acc_rnd = r_acc + ACC_W'(1 << (FRAC_SHIFT - 1));
    assign q       = acc_rnd[ACC_W-1:FRAC_SHIFT];
    assign q_sat   = !((&q[Q_W-1:SMP_W-1]) || !(|q[Q_W-1:SMP_W-1]));
    assign q_out   = q_sat ? (q[Q_W-1] ? SMP_MIN : SMP_MAX) : q[SMP_W-1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == AW'(MAX_SPAN)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    if (i_in_data.req_type == REQ_SAMPLE) begin
                        n_state = ST_START;
                    end else if ((i_in_data.req_type == REQ_WR_FF ||
                                  i_in_data.req_type == REQ_WR_FB) && idx_ok) begin
                        n_state = ST_COEF_RD;
                    end
                end
            end
            ST_COEF_RD: n_state = ST_COEF_WR;
            ST_COEF_WR: n_state = ST_IDLE;
            ST_START:   n_state = ST_FF;
            ST_FF:      n_state = ST_FB;
            ST_FB:      n_state = more_taps ? ST_FF : ST_SUM;
            ST_SUM:     n_state = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // Memory control and input stall.
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        hist_we    = 1'b0;
        hist_waddr = r_ptr;
        hist_wdata = {r_req.sample_in, q_out};
        hist_re    = 1'b0;
        hist_raddr = haddr0;
        coef_we    = 1'b0;
        coef_waddr = AW'(r_req.coef_index);
        coef_wdata = (r_req.req_type == REQ_WR_FF)
                     ? {r_req.coef_value, coef_rdata[COEF_W-1:0]}
                     : {coef_rdata[MW-1:COEF_W], r_req.coef_value};
        coef_re    = 1'b0;
        coef_raddr = n_clamp;
        case (r_state)
            ST_CLEAR: begin
                hist_we    = 1'b1;
                hist_waddr = r_clr;
                hist_wdata = '0;
                coef_we    = 1'b1;
                coef_waddr = r_clr;
                coef_wdata = '0;
            end
            ST_COEF_RD: begin
                coef_re    = 1'b1;
                coef_raddr = AW'(r_req.coef_index);
            end
            ST_COEF_WR: coef_we = 1'b1;
            ST_START: begin
                hist_re = 1'b1;
                coef_re = 1'b1;
            end
            ST_FB: begin
                hist_re    = more_taps;
                hist_raddr = haddr_next;
                coef_re    = more_taps;
                coef_raddr = k_next;
            end
            ST_FIN:  hist_we = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_span    <= '0;
            r_stride  <= STRIDE_W'(1);
            r_ptr     <= '0;
            r_clr     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SPAN:   r_span   <= i_cfg_data[SPAN_W-1:0];
                    CFG_STRIDE: r_stride <= i_cfg_data[STRIDE_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (r_state == ST_FIN && out_free) begin
                r_out_vld <= 1'b1;
                r_ptr     <= (r_ptr == AW'(MAX_SPAN)) ? '0 : r_ptr + AW'(1);
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_req <= i_in_data;
        end
        case (r_state)
            ST_START: begin
                r_k     <= n_clamp;
                r_haddr <= haddr0;
                r_prod  <= '0;
                r_acc   <= '0;
            end
            ST_FF: begin
                r_prod <= mul_p;
                r_acc  <= r_acc + ACC_W'(r_prod);
            end
            ST_FB: begin
                // The feedback term stops at delay one.
                r_prod <= (r_k == '0) ? '0 : mul_p;
                r_acc  <= r_acc + ACC_W'(r_prod);
                if (more_taps) begin
                    r_k     <= k_next;
                    r_haddr <= haddr_next;
                end
            end
            ST_SUM: begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            default: ;
        endcase
        if (r_state == ST_FIN && out_free) begin
            r_out.sample_out <= q_out;
            r_out.saturated  <= q_sat;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // Each row holds {x, y} for one history slot.
    iirst_ram #(
        .WIDTH (MW),
        .DEPTH (DEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_re    (hist_re),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    // Each row holds {b, a} for one delay index.
    iirst_ram #(
        .WIDTH (MW),
        .DEPTH (DEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (coef_wdata),
        .i_re    (coef_re),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rdata)
    );

endmodule

// ===== rtl/iirst_checker.sv =====
// Port-level checker for the strided-tap IIR filter, bound to the top level.
// Depends on iirst_pkg.
module iirst_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input iirst_pkg::t_in_item  i_in_data,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input iirst_pkg::t_out_item o_out_data,
    input logic                 i_out_stall
);

    import iirst_pkg::*;

    // A result waiting on a stalled output stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output result changed while stalled");

    // A new result only appears while the block is busy with a sample.
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without work in progress");

    // A sample transfer keeps the input stalled on the next cycle.
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.req_type == REQ_SAMPLE |=> o_in_stall)
        else $error("input not stalled after a sample transfer");

    // A saturated result carries one of the two limit values.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.saturated |->
            (o_out_data.sample_out == SMP_MAX || o_out_data.sample_out == SMP_MIN))
        else $error("saturated flag without a limit value");

endmodule

bind iir_filter_strided_taps iirst_checker u_iirst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);
